@@ src/sit_pkg.sv @@
// Shared types and constants for the sorted insert table.
package sit_pkg;

    localparam int DATA_WIDTH   = 32;
    localparam int IDX_W        = 5;
    localparam int DEF_CAPACITY = 16;

    typedef enum logic [1:0] {
        OP_INSERT_AT     = 2'd0,
        OP_SORTED_INSERT = 2'd1,
        OP_FIND          = 2'd2,
        OP_READ          = 2'd3
    } op_t;

    typedef enum logic [1:0] {
        ST_OK    = 2'd0,
        ST_FULL  = 2'd1,
        ST_RANGE = 2'd2
    } status_t;

    typedef struct packed {
        op_t                           op;
        logic signed [DATA_WIDTH-1:0]  value;
        logic [IDX_W-1:0]              position;
    } req_t;

    typedef struct packed {
        logic [IDX_W-1:0]              index_found;
        logic signed [DATA_WIDTH-1:0]  read_data;
        logic [IDX_W-1:0]              fill_count;
        status_t                       status;
    } rsp_t;

    typedef struct packed {
        logic load;
        logic shift;
        logic take_value;
        logic take_prev;
    } cell_ctrl_t;

endpackage

@@ src/sit_cell.sv @@
// One table cell: a stored entry and a scan lane that shifts toward cell zero.
module sit_cell
    import sit_pkg::*;
(
    input  logic                          clk,
    input  cell_ctrl_t                    ctrl,
    input  logic signed [DATA_WIDTH-1:0]  value,
    input  logic signed [DATA_WIDTH-1:0]  prev_entry,
    input  logic signed [DATA_WIDTH-1:0]  next_lane,
    output logic signed [DATA_WIDTH-1:0]  entry,
    output logic signed [DATA_WIDTH-1:0]  lane
);

    logic signed [DATA_WIDTH-1:0] entry_reg, entry_next;
    logic signed [DATA_WIDTH-1:0] lane_reg, lane_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctrl.take_value)
        begin
            entry_next = value;
        end
        else if (ctrl.take_prev)
        begin
            entry_next = prev_entry;
        end

        lane_next = lane_reg;
        if (ctrl.load)
        begin
            lane_next = entry_reg;
        end
        else if (ctrl.shift)
        begin
            lane_next = next_lane;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
        lane_reg  <= lane_next;
    end

    assign entry = entry_reg;
    assign lane  = lane_reg;

endmodule

@@ src/sorted_insert_table.sv @@
// Sorted insert table: a row of cells with a scan controller and a registered result word.
// A request word is taken only when idle. Inserts at a position and reads at or past the fill
// count finish in the first scan step; other reads scan to the position, searches to index_found,
// as the scan lane moves the stored entries past cell zero one cell per cycle. One request is
// in work at a time; its result waits in the hold register while the output one is occupied.
// Reset clears the fill count and the control state; entries hold no reset value and are
// never read before they are written, so there is no clearing pass.
module sorted_insert_table
    import sit_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    output logic req_ready,
    input  req_t req,
    output logic rsp_valid,
    input  logic rsp_ready,
    output rsp_t rsp
);

    // The count must hold CAPACITY itself; comparisons against the request position
    // are done at the wider of the two widths.
    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CMP_W = (CNT_W > IDX_W) ? CNT_W : IDX_W;

    typedef enum logic [1:0] {
        S_IDLE,
        S_SCAN,
        S_HOLD
    } state_t;

    state_t                        state_reg, state_next;
    logic [CNT_W-1:0]              count_reg, count_next;
    logic [CNT_W-1:0]              k_reg, k_next;
    logic                          rsp_valid_reg, rsp_valid_next;

    op_t                           op_reg, op_next;
    logic signed [DATA_WIDTH-1:0]  x_reg, x_next;
    logic [IDX_W-1:0]              pos_reg, pos_next;
    rsp_t                          rsp_reg, rsp_next;
    rsp_t                          hold_reg, hold_next;

    logic                          accept;
    logic                          rsp_free;
    logic                          full;
    logic                          hit;
    logic                          done;
    logic                          shift;
    logic                          commit;
    logic [CMP_W-1:0]              commit_p;
    logic [CMP_W-1:0]              cnt_c;
    logic [CMP_W-1:0]              pos_c;
    logic [CMP_W-1:0]              k_c;
    rsp_t                          res;

    cell_ctrl_t                    ctrl_w  [CAPACITY];
    logic signed [DATA_WIDTH-1:0]  entry_w [CAPACITY];
    logic signed [DATA_WIDTH-1:0]  lane_w  [CAPACITY];

    assign req_ready = (state_reg == S_IDLE);
    assign accept    = req_valid && req_ready;
    assign rsp_free  = !rsp_valid_reg || rsp_ready;
    assign full      = (count_reg == CNT_W'(CAPACITY));
    assign cnt_c     = CMP_W'(count_reg);
    assign pos_c     = CMP_W'(pos_reg);
    assign k_c       = CMP_W'(k_reg);

    // Cell zero's lane shows original entry k during the scan. One signed
    // comparator there serves the whole search.
    assign hit = (lane_w[0] >= x_reg);

    // Decide the current step of the scan. The table is changed only in the
    // cycle that finishes the operation, when the insert position is known.
    always_comb
    begin
        done     = 1'b0;
        shift    = 1'b0;
        commit   = 1'b0;
        commit_p = '0;
        res      = '{index_found: pos_reg, read_data: '0, fill_count: '0, status: ST_OK};

        if (state_reg == S_SCAN)
        begin
            case (op_reg)
                OP_INSERT_AT:
                begin
                    done     = 1'b1;
                    commit_p = pos_c;
                    if (full)
                    begin
                        res.status = ST_FULL;
                    end
                    else if (pos_c > cnt_c)
                    begin
                        res.status = ST_RANGE;
                    end
                    else
                    begin
                        commit = 1'b1;
                    end
                end
                OP_SORTED_INSERT, OP_FIND:
                begin
                    // Stop at the first entry not below the value, or past the
                    // last valid entry; the step count is then the slot.
                    if ((k_reg == count_reg) || hit)
                    begin
                        done            = 1'b1;
                        res.index_found = IDX_W'(k_reg);
                        commit_p        = k_c;
                        if (op_reg == OP_SORTED_INSERT)
                        begin
                            if (full)
                            begin
                                res.status = ST_FULL;
                            end
                            else
                            begin
                                commit = 1'b1;
                            end
                        end
                    end
                    else
                    begin
                        shift = 1'b1;
                    end
                end
                OP_READ:
                begin
                    if (pos_c >= cnt_c)
                    begin
                        done       = 1'b1;
                        res.status = ST_RANGE;
                    end
                    else if (k_c == pos_c)
                    begin
                        done          = 1'b1;
                        res.read_data = lane_w[0];
                    end
                    else
                    begin
                        shift = 1'b1;
                    end
                end
                default:
                begin
                    done = 1'b1;
                end
            endcase
        end

        res.fill_count = IDX_W'(count_reg + CNT_W'(commit));
    end

    // Next state, counters and the result registers. A finished result waits in
    // the hold register while the output register is still occupied.
    always_comb
    begin
        state_next     = state_reg;
        count_next     = count_reg + CNT_W'(commit);
        k_next         = k_reg;
        rsp_valid_next = rsp_valid_reg && !rsp_ready;
        op_next        = op_reg;
        x_next         = x_reg;
        pos_next       = pos_reg;
        rsp_next       = rsp_reg;
        hold_next      = hold_reg;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    state_next = S_SCAN;
                    k_next     = '0;
                    op_next    = req.op;
                    x_next     = req.value;
                    pos_next   = req.position;
                end
            end
            S_SCAN:
            begin
                if (shift)
                begin
                    k_next = k_reg + CNT_W'(1);
                end
                if (done)
                begin
                    if (rsp_free)
                    begin
                        rsp_next       = res;
                        rsp_valid_next = 1'b1;
                        state_next     = S_IDLE;
                    end
                    else
                    begin
                        hold_next  = res;
                        state_next = S_HOLD;
                    end
                end
            end
            S_HOLD:
            begin
                if (rsp_free)
                begin
                    rsp_next       = hold_reg;
                    rsp_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            count_reg     <= '0;
            k_reg         <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            k_reg         <= k_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        op_reg   <= op_next;
        x_reg    <= x_next;
        pos_reg  <= pos_next;
        rsp_reg  <= rsp_next;
        hold_reg <= hold_next;
    end

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

    // The cell row. On an insert, the cell at the position takes the value and
    // every valid cell above it takes its lower neighbor's entry. The lanes are
    // loaded from the entries when a word is accepted and then shift down.
    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        logic signed [DATA_WIDTH-1:0] prev_entry;
        logic signed [DATA_WIDTH-1:0] next_lane;

        if (i == 0)
        begin : g_first
            assign prev_entry = x_reg;
        end
        else
        begin : g_inner
            assign prev_entry = entry_w[i-1];
        end

        if (i == CAPACITY - 1)
        begin : g_last
            assign next_lane = '0;
        end
        else
        begin : g_body
            assign next_lane = lane_w[i+1];
        end

        assign ctrl_w[i] = '{
            load:       accept,
            shift:      shift,
            take_value: commit && (commit_p == CMP_W'(i)),
            take_prev:  commit && (commit_p < CMP_W'(i)) && (CMP_W'(i) <= cnt_c)
        };

        sit_cell u_cell (
            .clk        (clk),
            .ctrl       (ctrl_w[i]),
            .value      (x_reg),
            .prev_entry (prev_entry),
            .next_lane  (next_lane),
            .entry      (entry_w[i]),
            .lane       (lane_w[i])
        );
    end

    // An insert is only ever made into a table with room left.
    a_commit_not_full: assert property (@(posedge clk) disable iff (!rst_n)
        commit |-> !full)
        else $error("insert committed into a full table");

    // Each committed insert raises the fill count by exactly one.
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        commit |=> (count_reg == $past(count_reg) + CNT_W'(1)))
        else $error("fill count did not step after an insert");

    // The scan never moves past the last valid entry.
    a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
        shift |-> (k_reg < count_reg))
        else $error("scan ran past the fill count");

    // A result that waits for the output register is moved out before a new word is taken.
    a_hold_blocks: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_HOLD) |-> !req_ready)
        else $error("request taken while a result is held");

endmodule

@@ dv/sit_table_checker.sv @@
// Checker for the sorted insert table: watches both channels, predicts each result word, compares.
module sit_table_checker
    import sit_pkg::*;
#(
    parameter int CAPACITY = DEF_CAPACITY
)
(
    input  logic clk,
    input  logic rst_n,
    input  logic req_valid,
    input  logic req_ready,
    input  req_t req,
    input  logic rsp_valid,
    input  logic rsp_ready,
    input  rsp_t rsp,
    output int   error_count,
    output int   pending_results
);

    timeunit 1ns;
    timeprecision 1ps;

    localparam int REPORT_LIMIT = 10;

    // Shadow copy of the table contents and its fill count.
    logic signed [DATA_WIDTH-1:0] shadow_entries [CAPACITY];
    int                           shadow_count;

    // Result words predicted for accepted requests, oldest first.
    rsp_t expected_rsp_q [$];
    int   mismatches;

    // First entry greater than or equal to the key, or the fill count if there is none.
    function automatic int search_slot(input logic signed [DATA_WIDTH-1:0] key);
        for (int i = 0; i < shadow_count; i++)
        begin
            if (shadow_entries[i] >= key)
                return i;
        end
        return shadow_count;
    endfunction

    function automatic void shift_in(input int slot, input logic signed [DATA_WIDTH-1:0] key);
        for (int i = shadow_count; i > slot; i--)
            shadow_entries[i] = shadow_entries[i-1];
        shadow_entries[slot] = key;
        shadow_count++;
    endfunction

    // Applies one request word to the shadow table and returns the result word it should give.
    function automatic rsp_t apply_table_op(input req_t w);
        rsp_t                         r;
        logic signed [DATA_WIDTH-1:0] key;
        int                           slot;
        r      = '0;
        r.status = ST_OK;
        key    = w.value;
        case (w.op)
            OP_INSERT_AT:
            begin
                r.index_found = w.position;
                if (shadow_count >= CAPACITY)
                    r.status = ST_FULL;
                else if (int'(w.position) > shadow_count)
                    r.status = ST_RANGE;
                else
                    shift_in(int'(w.position), key);
            end
            OP_SORTED_INSERT:
            begin
                slot = search_slot(key);
                r.index_found = IDX_W'(slot);
                if (shadow_count >= CAPACITY)
                    r.status = ST_FULL;
                else
                    shift_in(slot, key);
            end
            OP_FIND:
            begin
                r.index_found = IDX_W'(search_slot(key));
            end
            default:
            begin
                r.index_found = w.position;
                if (int'(w.position) < shadow_count)
                    r.read_data = shadow_entries[w.position];
                else
                    r.status = ST_RANGE;
            end
        endcase
        r.fill_count = IDX_W'(shadow_count);
        return r;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        if (!rst_n)
        begin
            shadow_count = 0;
            mismatches   = 0;
            expected_rsp_q.delete();
            error_count     <= 0;
            pending_results <= 0;
        end
        else
        begin
            // The result side goes first so that a stray word cannot match a request of this edge.
            if (rsp_valid && rsp_ready)
            begin
                if (expected_rsp_q.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= REPORT_LIMIT)
                        $display("%0t: result word with nothing expected: index %0d data %0d fill %0d status %0d",
                                 $realtime, rsp.index_found, rsp.read_data, rsp.fill_count, rsp.status);
                end
                else
                begin
                    want = expected_rsp_q.pop_front();
                    if (rsp.index_found !== want.index_found || rsp.read_data !== want.read_data ||
                        rsp.fill_count !== want.fill_count || rsp.status !== want.status)
                    begin
                        mismatches++;
                        if (mismatches <= REPORT_LIMIT)
                            $display("%0t: result mismatch (expected/actual): index %0d/%0d data %0d/%0d fill %0d/%0d status %0d/%0d",
                                     $realtime, want.index_found, rsp.index_found,
                                     want.read_data, rsp.read_data,
                                     want.fill_count, rsp.fill_count,
                                     want.status, rsp.status);
                    end
                end
            end
            if (req_valid && req_ready)
                expected_rsp_q.push_back(apply_table_op(req));
            error_count     <= mismatches;
            pending_results <= expected_rsp_q.size();
        end
    end

endmodule

@@ dv/sorted_insert_table_tb.sv @@
// Top of the sorted insert table testbench: clock, reset, request and result stimulus, verdict.
module sorted_insert_table_tb;

    import sit_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    // The result side may stall for a long stretch at 48 percent idling, so the limit leaves a
    // wide margin over any sound run.
    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_WORDS  = 280;
    localparam int SETTLE_CYCLES = 24;

    localparam logic signed [DATA_WIDTH-1:0] VAL_MIN = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam logic signed [DATA_WIDTH-1:0] VAL_MAX = {1'b0, {(DATA_WIDTH-1){1'b1}}};

    logic clk = 1'b0;
    logic rst_n;
    logic req_valid;
    logic req_ready;
    req_t req;
    logic rsp_valid;
    logic rsp_ready = 1'b0;
    rsp_t rsp;

    int error_count;
    int pending_results;
    int cycle_count = 0;

    // Percent of cycles in which the request side holds back and the result side stalls.
    int tx_idle_pct;
    int rx_idle_pct;

    always #4 clk = ~clk;

    sorted_insert_table dut
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .req_valid (req_valid),
        .req_ready (req_ready),
        .req       (req),
        .rsp_valid (rsp_valid),
        .rsp_ready (rsp_ready),
        .rsp       (rsp)
    );

    sit_table_checker checker_i
    (
        .clk             (clk),
        .rst_n           (rst_n),
        .req_valid       (req_valid),
        .req_ready       (req_ready),
        .req             (req),
        .rsp_valid       (rsp_valid),
        .rsp_ready       (rsp_ready),
        .rsp             (rsp),
        .error_count     (error_count),
        .pending_results (pending_results)
    );

    // The result side stalls at random, one decision per cycle.
    always @(posedge clk)
    begin
        rsp_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
    end

    // Watchdog: a hung block or a lost result word ends the run here.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Presents one request word and returns at the edge where it is accepted. Valid stays high
    // afterwards, so a following word without a gap goes out back to back.
    task automatic issue_word(input op_t op, input logic signed [DATA_WIDTH-1:0] v,
                              input logic [IDX_W-1:0] p);
        req_t w;
        w.op       = op;
        w.value    = v;
        w.position = p;
        while ($urandom_range(0, 99) < tx_idle_pct)
        begin
            req_valid <= 1'b0;
            @(posedge clk);
        end
        req_valid <= 1'b1;
        req       <= w;
        @(posedge clk);
        while (!req_ready)
            @(posedge clk);
    endtask

    // Drops valid and holds off until every predicted result word has come back. The count
    // from the checker is registered, so the first look is taken at the edge after the last accept.
    task automatic wait_drained();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending_results != 0)
            @(posedge clk);
    endtask

    // Values lean toward a narrow band around zero so that equal entries and ties in the
    // search come up often; the rest are extremes or fully random words.
    function automatic logic signed [DATA_WIDTH-1:0] pick_value();
        case ($urandom_range(0, 7))
            0, 1, 2: return DATA_WIDTH'($signed($urandom_range(0, 16)) - 8);
            3:
            begin
                case ($urandom_range(0, 4))
                    0: return VAL_MIN;
                    1: return VAL_MAX;
                    2: return '1;
                    3: return '0;
                    default: return DATA_WIDTH'(1);
                endcase
            end
            default: return DATA_WIDTH'($urandom);
        endcase
    endfunction

    // Positions mostly stay within the table; now and then one reaches the top of the field.
    function automatic logic [IDX_W-1:0] pick_position();
        if ($urandom_range(0, 7) == 0)
            return IDX_W'($urandom_range(0, (1 << IDX_W) - 1));
        return IDX_W'($urandom_range(0, DEF_CAPACITY));
    endfunction

    // Random traffic. Inserts are rare, so the table fills slowly from the eight entries that
    // the directed words leave, and finds and reads see it at each fill level above that; once
    // full, every insert of either kind must be refused at any position.
    task automatic random_words(input int n);
        int pick;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(0, 99);
            if (pick < 6)
                issue_word(OP_INSERT_AT, pick_value(), pick_position());
            else if (pick < 12)
                issue_word(OP_SORTED_INSERT, pick_value(), pick_position());
            else if (pick < 56)
                issue_word(OP_FIND, pick_value(), pick_position());
            else
                issue_word(OP_READ, pick_value(), pick_position());
        end
    endtask

    initial
    begin
        rst_n       = 1'b0;
        req_valid   = 1'b0;
        req         = '0;
        tx_idle_pct = 7;
        rx_idle_pct = 48;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed words on the empty table. A read at the fill count or an insert past it must be
        // refused, and a search of an empty table lands at index zero.
        issue_word(OP_READ,          '0,      IDX_W'(0));
        issue_word(OP_FIND,          '0,      IDX_W'(0));
        issue_word(OP_INSERT_AT,     VAL_MAX, IDX_W'(1));
        issue_word(OP_INSERT_AT,     '1,      '1);
        // Sorted inserts: the first lands at zero, a larger value goes to the end, the most
        // negative value goes to the front, and an equal value goes before its twin.
        issue_word(OP_SORTED_INSERT, '0,      IDX_W'(0));
        issue_word(OP_SORTED_INSERT, VAL_MAX, '1);
        issue_word(OP_SORTED_INSERT, VAL_MIN, IDX_W'(0));
        issue_word(OP_SORTED_INSERT, '0,      IDX_W'(9));
        // Insert at the front out of order, then search for the largest value: only the last
        // entry matches, which checks that the search covers it.
        issue_word(OP_INSERT_AT,     '1,      IDX_W'(0));
        issue_word(OP_FIND,          VAL_MAX, IDX_W'(0));
        issue_word(OP_FIND,          '1,      IDX_W'(0));
        issue_word(OP_FIND,          VAL_MIN, IDX_W'(0));
        // Inserts at the fill count and in the middle, with alternating bit patterns.
        issue_word(OP_INSERT_AT,     DATA_WIDTH'(32'h5555_5555), IDX_W'(5));
        issue_word(OP_INSERT_AT,     DATA_WIDTH'(32'hAAAA_AAAA), IDX_W'(2));
        issue_word(OP_SORTED_INSERT, DATA_WIDTH'(32'hAAAA_AAAA), IDX_W'(0));
        // Reads of the first, a middle and the last entry, then at the fill count and far beyond it.
        issue_word(OP_READ,          '0,      IDX_W'(0));
        issue_word(OP_READ,          '0,      IDX_W'(3));
        issue_word(OP_READ,          '0,      IDX_W'(7));
        issue_word(OP_READ,          '0,      IDX_W'(8));
        issue_word(OP_READ,          '0,      IDX_W'(DEF_CAPACITY));
        issue_word(OP_READ,          '0,      '1);
        wait_drained();

        // Three idling patterns: request side mostly busy, result side mostly busy, no idling.
        for (int phase = 0; phase < 3; phase++)
        begin
            case (phase)
                0:
                begin
                    tx_idle_pct = 7;
                    rx_idle_pct = 48;
                end
                1:
                begin
                    tx_idle_pct = 48;
                    rx_idle_pct = 7;
                end
                default:
                begin
                    tx_idle_pct = 0;
                    rx_idle_pct = 0;
                end
            endcase
            random_words(RANDOM_WORDS);
            wait_drained();
        end

        // Give any stray result word time to show up before the verdict.
        repeat (SETTLE_CYCLES) @(posedge clk);
        if (error_count == 0 && pending_results == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
